// ----- src/mtq_pkg.sv -----
// shared types and constants for the scrolling text marquee
// no dependencies

package mtq_pkg;

	// field widths of the channels, configuration and text memory
	localparam int OP_W       = 2;
	localparam int CHAR_W     = 8;
	localparam int POS_W      = 5;
	localparam int IDX_W      = 3;
	localparam int PERIOD_W   = 8;
	localparam int DELAY_W    = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam int MAX_ADDR_W = 8;

	// display geometry, fixed codes and register reset values
	localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;
	localparam logic [POS_W-1:0]    DISPLAY_BASE = 5'd6;
	localparam logic [POS_W-1:0]    ROW_CELLS    = 5'd7;
	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd50;
	localparam logic [DELAY_W-1:0]  DELAY_RST    = 10'd150;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 1'b1;

	// request operations
	typedef enum logic [OP_W-1:0] {
		OP_TICK = 2'd0,
		OP_LOAD = 2'd1,
		OP_STOP = 2'd2
	} op_t;

	// configuration seen by the controller
	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [DELAY_W-1:0]  delay;
	} cfg_t;

	// text memory access from the controller
	typedef struct packed {
		logic                  we;
		logic [MAX_ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0]     wdata;
		logic                  re;
		logic [MAX_ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// ----- src/mtq_ifs.sv -----
// request and result channel interfaces of the marquee
// depends on mtq_pkg for field widths

interface mtq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [mtq_pkg::OP_W-1:0]    op;
	logic [mtq_pkg::CHAR_W-1:0]  char_code;
	logic                        row;
	logic                        last_char;

	modport source (output valid, op, char_code, row, last_char, input ready);
	modport sink (input valid, op, char_code, row, last_char, output ready);
endinterface

interface mtq_disp_if;
	logic                        valid;
	logic                        ready;
	logic [mtq_pkg::POS_W-1:0]   display_position;
	logic [mtq_pkg::IDX_W-1:0]   char_index;
	logic [mtq_pkg::CHAR_W-1:0]  char_code_res;
	logic                        last_of_window;

	modport source (output valid, display_position, char_index, char_code_res,
		last_of_window, input ready);
	modport sink (input valid, display_position, char_index, char_code_res,
		last_of_window, output ready);
endinterface

// ----- src/mtq_text_ram.sv -----
// text store: one write port, one read port with registered read data
// depends on mtq_pkg for the access struct

module mtq_text_ram #(
	parameter int DEPTH = 128
) (
	input  logic                       clk,
	input  mtq_pkg::ram_req_t          req,
	output logic [mtq_pkg::CHAR_W-1:0] rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [mtq_pkg::CHAR_W-1:0] text_mem_q [DEPTH];
	logic [mtq_pkg::CHAR_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			text_mem_q[req.waddr[AW-1:0]] <= req.wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= text_mem_q[req.raddr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/mtq_ctrl.sv -----
// marquee sequencer: load compare, tick timing, window print and result register
// depends on mtq_pkg and the channel interfaces; drives mtq_text_ram

module mtq_ctrl #(
	parameter int TEXT_DEPTH   = 128,
	parameter int WINDOW_WIDTH = 7,
	parameter int LEAD_SPACES  = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mtq_pkg::cfg_t              cfg,
	mtq_cmd_if.sink                    cmd,
	mtq_disp_if.source                 disp,
	output mtq_pkg::ram_req_t          ram_req,
	input  logic [mtq_pkg::CHAR_W-1:0] ram_rdata
);

	localparam int AW       = $clog2(TEXT_DEPTH);
	localparam int LW       = $clog2(TEXT_DEPTH + 1);
	localparam int PW       = AW + 1;
	localparam int WW       = (WINDOW_WIDTH > 1) ? $clog2(WINDOW_WIDTH) : 1;
	localparam int KEEP_MAX = TEXT_DEPTH - LEAD_SPACES;
	localparam int POS_W    = mtq_pkg::POS_W;
	localparam int IDX_W    = mtq_pkg::IDX_W;
	localparam int MAW      = mtq_pkg::MAX_ADDR_W;
	localparam int PCW      = mtq_pkg::PERIOD_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_PR_RD  = 4'b0100,
		ST_PR_OUT = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [mtq_pkg::CHAR_W-1:0]    ch_q;
	logic                          row_q;
	logic                          last_q;
	logic [LW-1:0]                 len_q;
	logic [AW-1:0]                 off_q;
	logic                          shown_q;
	logic [LW-1:0]                 ldcnt_q;
	logic                          differs_q;
	logic                          pend_q;
	logic [mtq_pkg::DELAY_W-1:0]   dcnt_q;
	logic                          run_q;
	logic [mtq_pkg::PERIOD_W-1:0]  pcnt_q;
	logic [WW-1:0]                 cell_q;
	logic                          pad_s1;

	logic                          ov_q;
	logic [POS_W-1:0]              opos_q;
	logic [IDX_W-1:0]              oidx_q;
	logic [mtq_pkg::CHAR_W-1:0]    ochar_q;
	logic                          olast_q;

	logic                          accept;
	logic                          is_load;
	logic [PW-1:0]                 idx_ld;
	logic                          in_rng;
	logic                          diff_n;
	logic [LW-1:0]                 kept;
	logic [LW-1:0]                 new_len;
	logic                          same;
	logic                          active;
	logic [WW-1:0]                 cell_rd;
	logic [PW-1:0]                 pos;
	logic                          pad;
	logic                          slot_free;
	logic                          cell_last;
	logic [PCW-1:0]                pc_inc;
	logic [LW-1:0]                 off_inc;
	logic [AW-1:0]                 off_step;
	logic [POS_W-1:0]              cell_pos;

	// request handshake
	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign is_load   = (cmd.op == mtq_pkg::OP_LOAD);

	// load compare against the stored character
	assign idx_ld  = PW'(LEAD_SPACES) + PW'(ldcnt_q);
	assign in_rng  = (ldcnt_q < LW'(KEEP_MAX));
	assign diff_n  = differs_q || !in_rng ||
		(idx_ld >= PW'(len_q)) || (ram_rdata != ch_q);
	assign kept    = in_rng ? (ldcnt_q + LW'(1)) : ldcnt_q;
	assign new_len = LW'(LEAD_SPACES) + kept;
	assign same    = !diff_n && (new_len == len_q) && (row_q == shown_q);
	assign active  = pend_q || run_q;

	// window cell address and padding
	assign cell_rd   = (state_q == ST_PR_OUT) ? (cell_q + WW'(1)) : cell_q;
	assign pos       = PW'(off_q) + PW'(cell_rd);
	assign pad       = (pos < PW'(LEAD_SPACES)) || (pos >= PW'(len_q));
	assign slot_free = !ov_q || disp.ready;
	assign cell_last = (cell_q == WW'(WINDOW_WIDTH - 1));
	assign cell_pos  = POS_W'(cell_q);

	// tick arithmetic
	assign pc_inc   = PCW'(pcnt_q) + PCW'(1);
	assign off_inc  = LW'(off_q) + LW'(1);
	assign off_step = (off_inc >= len_q) ? AW'(0) : AW'(off_inc);

	// text memory requests
	always_comb begin
		ram_req       = '0;
		ram_req.we    = (state_q == ST_LOAD) && in_rng;
		ram_req.waddr = MAW'(idx_ld);
		ram_req.wdata = ch_q;
		ram_req.re    = (accept && is_load) || (state_q == ST_PR_RD) ||
			((state_q == ST_PR_OUT) && slot_free && !cell_last);
		ram_req.raddr = (state_q == ST_IDLE) ? MAW'(idx_ld) : MAW'(pos);
	end

	// result register
	assign disp.valid            = ov_q;
	assign disp.display_position = opos_q;
	assign disp.char_index       = oidx_q;
	assign disp.char_code_res    = ochar_q;
	assign disp.last_of_window   = olast_q;

	// result valid: set by a printed cell, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if ((state_q == ST_PR_OUT) && slot_free) begin
			ov_q <= 1'b1;
		end else if (disp.ready) begin
			ov_q <= 1'b0;
		end
	end

	// sequencer and marquee state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= '0;
			off_q     <= '0;
			shown_q   <= 1'b0;
			ldcnt_q   <= '0;
			differs_q <= 1'b0;
			pend_q    <= 1'b0;
			dcnt_q    <= '0;
			run_q     <= 1'b0;
			pcnt_q    <= '0;
			cell_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q   <= cmd.char_code;
						row_q  <= cmd.row;
						last_q <= cmd.last_char;
						cell_q <= '0;
						unique case (mtq_pkg::op_t'(cmd.op))
							mtq_pkg::OP_TICK: begin
								// start delay first, then the scroll period
								if (pend_q) begin
									if (dcnt_q <= mtq_pkg::DELAY_W'(1)) begin
										pend_q  <= 1'b0;
										run_q   <= 1'b1;
										pcnt_q  <= '0;
										off_q   <= off_step;
										state_q <= ST_PR_RD;
									end else begin
										dcnt_q <= dcnt_q - mtq_pkg::DELAY_W'(1);
									end
								end else if (run_q) begin
									if (pc_inc >= PCW'(cfg.period)) begin
										pcnt_q  <= '0;
										off_q   <= off_step;
										state_q <= ST_PR_RD;
									end else begin
										pcnt_q <= mtq_pkg::PERIOD_W'(pc_inc);
									end
								end
							end
							mtq_pkg::OP_LOAD: begin
								state_q <= ST_LOAD;
							end
							mtq_pkg::OP_STOP: begin
								pend_q <= 1'b0;
								run_q  <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOAD: begin
					// stored character is back: compare, write, maybe finish the text
					state_q <= ST_IDLE;
					if (!last_q) begin
						differs_q <= diff_n;
						ldcnt_q   <= kept;
					end else begin
						ldcnt_q   <= '0;
						differs_q <= 1'b0;
						if (!(active && same)) begin
							len_q   <= new_len;
							shown_q <= row_q;
							off_q   <= AW'(LEAD_SPACES);
							state_q <= ST_PR_RD;
							if (kept > LW'(WINDOW_WIDTH)) begin
								run_q  <= 1'b0;
								pcnt_q <= '0;
								pend_q <= 1'b1;
								dcnt_q <= cfg.delay;
							end else begin
								pend_q <= 1'b0;
								run_q  <= 1'b0;
							end
						end
					end
				end
				ST_PR_RD: begin
					pad_s1  <= pad;
					state_q <= ST_PR_OUT;
				end
				ST_PR_OUT: begin
					// one cell per cycle while the result register drains
					if (slot_free) begin
						opos_q  <= (shown_q ? mtq_pkg::ROW_CELLS : POS_W'(0)) +
							mtq_pkg::DISPLAY_BASE + cell_pos;
						oidx_q  <= IDX_W'(cell_q);
						ochar_q <= pad_s1 ? mtq_pkg::SPACE_CODE : ram_rdata;
						olast_q <= cell_last;
						if (cell_last) begin
							state_q <= ST_IDLE;
						end else begin
							cell_q <= cell_rd;
							pad_s1 <= pad;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/scrolling_text_marquee_top.sv -----
// Scrolling text marquee, top level.
// Requests arrive on cmd (op, char_code, row, last_char) with valid/ready;
// printed cells leave on disp (display_position, char_index, char_code_res,
// last_of_window) with valid/ready. Registers are written on cfg_we:
// index 0 scroll period in ticks, index 1 start delay in ticks.
// A load request reads the stored character from the text memory, compares it
// with the new one and writes the new one; a tick or stop request that does
// not print leaves the sequencer idle. A printed window is WINDOW_WIDTH results,
// one per cycle while disp does not stall; after a tick is taken the first
// result passes the read state and then the output state, and after the final
// load the load state comes before them; cells share the single memory read port.
// cmd.ready is high whenever no request is in progress; a finished result
// may still sit in the output register meanwhile.
// When disp stalls, printing halts on the pending cell and resumes without
// loss once it is taken.
// Reset clears the scroll state and loads the default period and delay; the
// text memory is not cleared and the lead-in spaces are generated, not stored.
// depends on mtq_pkg, mtq_ifs, mtq_text_ram and mtq_ctrl

module scrolling_text_marquee_top #(
	parameter int TEXT_DEPTH   = 128,
	parameter int WINDOW_WIDTH = 7,
	parameter int LEAD_SPACES  = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mtq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtq_pkg::CFG_DATA_W-1:0] cfg_data,
	mtq_cmd_if.sink                        cmd,
	mtq_disp_if.source                     disp
);

	mtq_pkg::cfg_t              cfg_q;
	mtq_pkg::ram_req_t          ram_req;
	logic [mtq_pkg::CHAR_W-1:0] ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period <= mtq_pkg::PERIOD_RST;
			cfg_q.delay  <= mtq_pkg::DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtq_pkg::CFG_PERIOD: cfg_q.period <= cfg_data[mtq_pkg::PERIOD_W-1:0];
				mtq_pkg::CFG_DELAY:  cfg_q.delay  <= cfg_data[mtq_pkg::DELAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// text memory
	mtq_text_ram #(
		.DEPTH(TEXT_DEPTH)
	) u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// sequencer
	mtq_ctrl #(
		.TEXT_DEPTH  (TEXT_DEPTH),
		.WINDOW_WIDTH(WINDOW_WIDTH),
		.LEAD_SPACES (LEAD_SPACES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.disp     (disp),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata)
	);

endmodule
